@@ src/aqpc_pkg.sv @@
package aqpc_pkg;

  // defaults for the top-level parameters
  localparam int FRAC_BITS_DEF   = 16;
  localparam int VALUE_WIDTH_DEF = 32;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_CODE_BITS    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIGNED_CODES = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_SCALE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CODE_OFFSET  = 3'd4;

  // register reset values
  localparam logic        CODE_BITS_RST    = 1'b0;
  localparam logic        SIGNED_CODES_RST = 1'b1;
  localparam logic [31:0] INV_SCALE_RST    = 32'h0001_0000;
  localparam logic [31:0] SCALE_RST        = 32'h0001_0000;
  localparam logic [15:0] CODE_OFFSET_RST  = 16'h0000;

  // operations and code widths
  localparam logic OP_QUANT   = 1'b0;
  localparam logic OP_DEQUANT = 1'b1;
  localparam logic CB_8BIT    = 1'b0;
  localparam logic CB_4BIT    = 1'b1;

  // per-lane code: covers -128..255
  localparam int CODE_W = 9;
  // code minus zero point
  localparam int DIFF_W = 17;
  // integer part of |value| * inv_scale, capped at 2^24
  localparam int Q_W    = 25;
  localparam logic [Q_W-1:0] QCAP = 25'h100_0000;
  // rounding sum
  localparam int N_W    = 27;

  // clip ranges
  localparam logic signed [CODE_W-1:0] CLIP_S8_LO = -9'sd128;
  localparam logic signed [CODE_W-1:0] CLIP_S8_HI = 9'sd127;
  localparam logic signed [CODE_W-1:0] CLIP_U8_LO = 9'sd0;
  localparam logic signed [CODE_W-1:0] CLIP_U8_HI = 9'sd255;
  localparam logic signed [CODE_W-1:0] CLIP_S4_LO = -9'sd8;
  localparam logic signed [CODE_W-1:0] CLIP_S4_HI = 9'sd7;
  localparam logic signed [CODE_W-1:0] CLIP_U4_LO = 9'sd0;
  localparam logic signed [CODE_W-1:0] CLIP_U4_HI = 9'sd15;

  typedef struct packed {
    logic [31:0]               inv_scale;
    logic [31:0]               scale;
    logic signed [15:0]        code_offset;
    logic signed [CODE_W-1:0]  clip_lo;
    logic signed [CODE_W-1:0]  clip_hi;
  } aqpc_cfg_t;

  // stage load strobes
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } aqpc_en_t;

  // per-request control carried down the pipe
  typedef struct packed {
    logic op;
    logic has_hi;
  } aqpc_tag_t;

endpackage

@@ src/aqpc_lane.sv @@
module aqpc_lane #(
  parameter int FRAC_BITS   = aqpc_pkg::FRAC_BITS_DEF,
  parameter int VALUE_WIDTH = aqpc_pkg::VALUE_WIDTH_DEF
) (
  input  logic                                 clk_i,
  input  aqpc_pkg::aqpc_en_t                   en_i,
  input  aqpc_pkg::aqpc_cfg_t                  cfg_i,
  input  logic signed [VALUE_WIDTH-1:0]        value_i,
  input  logic signed [aqpc_pkg::CODE_W-1:0]   code_i,
  output logic signed [aqpc_pkg::CODE_W-1:0]   code_o,
  output logic signed [VALUE_WIDTH-1:0]        real_o
);

  localparam int RSH  = 2 * FRAC_BITS;
  localparam int DP_W = aqpc_pkg::DIFF_W + 33;
  localparam logic signed [DP_W-1:0] RMAX =
    DP_W'((64'd1 << (VALUE_WIDTH - 1)) - 64'd1);
  localparam logic signed [DP_W-1:0] RMIN = -RMAX - DP_W'(1);

  // stage 1: magnitude, code minus zero point
  logic [VALUE_WIDTH-1:0]               val_u;
  logic                                 neg_d, neg1_q;
  logic [VALUE_WIDTH-1:0]               mag_d, mag_q;
  logic signed [aqpc_pkg::DIFF_W-1:0]   diff_d, diff_q;

  assign val_u  = value_i;
  assign neg_d  = value_i[VALUE_WIDTH-1];
  assign mag_d  = neg_d ? (~val_u + {{(VALUE_WIDTH-1){1'b0}}, 1'b1}) : val_u;
  assign diff_d = $signed({{(aqpc_pkg::DIFF_W-aqpc_pkg::CODE_W){code_i[aqpc_pkg::CODE_W-1]}},
                           code_i}
                          - {cfg_i.code_offset[15], cfg_i.code_offset});

  always_ff @(posedge clk_i) begin
    if (en_i.s1) begin
      neg1_q <= neg_d;
      mag_q  <= mag_d;
      diff_q <= diff_d;
    end
  end

  // stage 2: partial products and dequantize product
  logic [63:0]             mag_ext;
  logic [63:0]             plo_d, plo_q, phi_d, phi_q;
  logic                    neg2_q;
  logic signed [DP_W-1:0]  dprod_d, dprod_q;

  assign mag_ext = 64'(mag_q);
  assign plo_d   = {32'b0, mag_ext[31:0]} * {32'b0, cfg_i.inv_scale};
  assign phi_d   = {32'b0, mag_ext[63:32]} * {32'b0, cfg_i.inv_scale};
  assign dprod_d = $signed({{33{diff_q[aqpc_pkg::DIFF_W-1]}}, diff_q})
                 * $signed({{(DP_W-32){1'b0}}, cfg_i.scale});

  always_ff @(posedge clk_i) begin
    if (en_i.s2) begin
      plo_q   <= plo_d;
      phi_q   <= phi_d;
      neg2_q  <= neg1_q;
      dprod_q <= dprod_d;
    end
  end

  // stage 3: combine limbs, integer part, rounding bits, saturate
  logic [95:0]                    psum, qfull;
  logic [aqpc_pkg::Q_W-1:0]       q_d, q_q;
  logic                           hb_d, hb_q, lz_d, lz_q, neg3_q;
  logic signed [VALUE_WIDTH-1:0]  real_d;

  assign psum  = {phi_q, 32'b0} + {32'b0, plo_q};
  assign qfull = psum >> RSH;
  assign q_d   = (qfull > 96'(aqpc_pkg::QCAP)) ? aqpc_pkg::QCAP : qfull[aqpc_pkg::Q_W-1:0];
  assign hb_d  = psum[RSH-1];
  assign lz_d  = ~|psum[RSH-2:0];

  always_comb begin
    if (dprod_q > RMAX) begin
      real_d = RMAX[VALUE_WIDTH-1:0];
    end else if (dprod_q < RMIN) begin
      real_d = RMIN[VALUE_WIDTH-1:0];
    end else begin
      real_d = dprod_q[VALUE_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s3) begin
      q_q    <= q_d;
      hb_q   <= hb_d;
      lz_q   <= lz_d;
      neg3_q <= neg2_q;
      real_o <= real_d;
    end
  end

  // stage 4 logic: add zero point, round half away from zero, clip
  logic signed [aqpc_pkg::N_W-1:0] zp_ext, q_ext, n0, n1, lo_ext, hi_ext, nc;
  logic                            rz, up;

  assign zp_ext = {{(aqpc_pkg::N_W-16){cfg_i.code_offset[15]}}, cfg_i.code_offset};
  assign q_ext  = {{(aqpc_pkg::N_W-aqpc_pkg::Q_W){1'b0}}, q_q};
  assign lo_ext = {{(aqpc_pkg::N_W-aqpc_pkg::CODE_W){cfg_i.clip_lo[aqpc_pkg::CODE_W-1]}},
                   cfg_i.clip_lo};
  assign hi_ext = {{(aqpc_pkg::N_W-aqpc_pkg::CODE_W){cfg_i.clip_hi[aqpc_pkg::CODE_W-1]}},
                   cfg_i.clip_hi};
  assign rz     = !hb_q && lz_q;

  always_comb begin
    if (!neg3_q) begin
      n0 = q_ext + zp_ext;
      up = !n0[aqpc_pkg::N_W-1] ? hb_q : (hb_q && !lz_q);
    end else begin
      n0 = zp_ext - q_ext - {{(aqpc_pkg::N_W-1){1'b0}}, !rz};
      up = !n0[aqpc_pkg::N_W-1] ? (!rz && (!hb_q || lz_q)) : (!rz && !hb_q);
    end
    n1 = n0 + {{(aqpc_pkg::N_W-1){1'b0}}, up};
    if (n1 < lo_ext) begin
      nc = lo_ext;
    end else if (n1 > hi_ext) begin
      nc = hi_ext;
    end else begin
      nc = n1;
    end
  end

  assign code_o = nc[aqpc_pkg::CODE_W-1:0];

endmodule

@@ src/aqpc_merge.sv @@
module aqpc_merge #(
  parameter int VALUE_WIDTH = aqpc_pkg::VALUE_WIDTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                load_i,
  input  aqpc_pkg::aqpc_tag_t                 tag_i,
  input  logic                                code_bits_i,
  input  logic signed [aqpc_pkg::CODE_W-1:0]  lo_code_i,
  input  logic signed [aqpc_pkg::CODE_W-1:0]  hi_code_i,
  input  logic signed [VALUE_WIDTH-1:0]       lo_real_i,
  input  logic signed [VALUE_WIDTH-1:0]       hi_real_i,
  output logic [7:0]                          code_out_o,
  output logic signed [VALUE_WIDTH-1:0]       real_lo_o,
  output logic signed [VALUE_WIDTH-1:0]       real_hi_o
);

  logic [7:0]                     code_d;
  logic signed [VALUE_WIDTH-1:0]  lo_d, hi_d;

  always_comb begin
    code_d = '0;
    lo_d   = '0;
    hi_d   = '0;
    if (tag_i.op == aqpc_pkg::OP_QUANT) begin
      if (code_bits_i == aqpc_pkg::CB_8BIT) begin
        code_d = lo_code_i[7:0];
      end else begin
        // pack low nibble first; odd tail leaves the upper nibble zero
        code_d = {tag_i.has_hi ? hi_code_i[3:0] : 4'h0, lo_code_i[3:0]};
      end
    end else begin
      lo_d = lo_real_i;
      if (code_bits_i == aqpc_pkg::CB_4BIT) begin
        hi_d = hi_real_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      code_out_o <= code_d;
      real_lo_o  <= lo_d;
      real_hi_o  <= hi_d;
    end
  end

endmodule

@@ src/affine_quantize_pack_codec_unit.sv @@
// Affine quantize/dequantize codec. A quantize request (operation 0) scales
// value_lo (and value_hi in 4-bit mode) by inv_scale, adds the zero point, rounds
// half away from zero and clips to the 8-bit or 4-bit, signed or unsigned
// code range; 4-bit codes come back packed in code_out low nibble first, and
// has_hi low gives a zero upper nibble. A dequantize request (operation 1)
// unpacks code_in, subtracts the zero point, multiplies by scale and saturates
// to the signed Q format on real_lo/real_hi. Unused result fields read zero.
// Throughput is one request per clock while results are taken; the lane
// pipeline registers operand prep at accept, then the split 32x32 multiply,
// limb combine, then round/clip into the output register.
// The pipeline only stalls when the output register holds a result that is
// not taken. Write configuration while no request is in flight; writes are
// always accepted.
module affine_quantize_pack_codec_unit #(
  parameter int FRAC_BITS   = aqpc_pkg::FRAC_BITS_DEF,
  parameter int VALUE_WIDTH = aqpc_pkg::VALUE_WIDTH_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // input requests
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic                                 operation_i,
  input  logic signed [VALUE_WIDTH-1:0]        value_lo_i,
  input  logic signed [VALUE_WIDTH-1:0]        value_hi_i,
  input  logic                                 has_hi_i,
  input  logic [7:0]                           code_in_i,
  // results
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [7:0]                           code_out_o,
  output logic signed [VALUE_WIDTH-1:0]        real_lo_o,
  output logic signed [VALUE_WIDTH-1:0]        real_hi_o,
  // configuration writes
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [aqpc_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [aqpc_pkg::CFG_DATA_W-1:0]      cfg_data_i
);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic               code_bits_q, code_bits_d;
  logic               signed_codes_q, signed_codes_d;
  logic [31:0]        inv_scale_q, inv_scale_d;
  logic [31:0]        scale_q, scale_d;
  logic signed [15:0] code_offset_q, code_offset_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    code_bits_d    = code_bits_q;
    signed_codes_d = signed_codes_q;
    inv_scale_d    = inv_scale_q;
    scale_d        = scale_q;
    code_offset_d  = code_offset_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        aqpc_pkg::CFG_CODE_BITS:    code_bits_d    = cfg_data_i[0];
        aqpc_pkg::CFG_SIGNED_CODES: signed_codes_d = cfg_data_i[0];
        aqpc_pkg::CFG_INV_SCALE:    inv_scale_d    = cfg_data_i[31:0];
        aqpc_pkg::CFG_SCALE:        scale_d        = cfg_data_i[31:0];
        aqpc_pkg::CFG_CODE_OFFSET:  code_offset_d  = $signed(cfg_data_i[15:0]);
        default: ; // drop writes to unmapped indexes
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      code_bits_q    <= aqpc_pkg::CODE_BITS_RST;
      signed_codes_q <= aqpc_pkg::SIGNED_CODES_RST;
      inv_scale_q    <= aqpc_pkg::INV_SCALE_RST;
      scale_q        <= aqpc_pkg::SCALE_RST;
      code_offset_q  <= $signed(aqpc_pkg::CODE_OFFSET_RST);
    end else begin
      code_bits_q    <= code_bits_d;
      signed_codes_q <= signed_codes_d;
      inv_scale_q    <= inv_scale_d;
      scale_q        <= scale_d;
      code_offset_q  <= code_offset_d;
    end
  end

  // Clip range follows code width and signedness.
  aqpc_pkg::aqpc_cfg_t cfg;

  always_comb begin
    cfg.inv_scale   = inv_scale_q;
    cfg.scale       = scale_q;
    cfg.code_offset = code_offset_q;
    if (code_bits_q == aqpc_pkg::CB_8BIT) begin
      cfg.clip_lo = signed_codes_q ? aqpc_pkg::CLIP_S8_LO : aqpc_pkg::CLIP_U8_LO;
      cfg.clip_hi = signed_codes_q ? aqpc_pkg::CLIP_S8_HI : aqpc_pkg::CLIP_U8_HI;
    end else begin
      cfg.clip_lo = signed_codes_q ? aqpc_pkg::CLIP_S4_LO : aqpc_pkg::CLIP_U4_LO;
      cfg.clip_hi = signed_codes_q ? aqpc_pkg::CLIP_S4_HI : aqpc_pkg::CLIP_U4_HI;
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline control: each stage advances when the next one is free, so
  // bubbles collapse and a waiting result stalls only what is behind it.
  // ---------------------------------------------------------------------------
  logic vld1_q, vld2_q, vld3_q, vld4_q;
  logic free1, free2, free3, free4;
  aqpc_pkg::aqpc_en_t en;

  assign free4  = !vld4_q || out_ready_i;
  assign en.s4  = vld3_q && free4;
  assign free3  = !vld3_q || en.s4;
  assign en.s3  = vld2_q && free3;
  assign free2  = !vld2_q || en.s3;
  assign en.s2  = vld1_q && free2;
  assign free1  = !vld1_q || en.s2;
  assign en.s1  = in_valid_i && free1;

  assign in_ready_o  = free1;
  assign out_valid_o = vld4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
      vld3_q <= 1'b0;
      vld4_q <= 1'b0;
    end else begin
      vld1_q <= en.s1 || (vld1_q && !en.s2);
      vld2_q <= en.s2 || (vld2_q && !en.s3);
      vld3_q <= en.s3 || (vld3_q && !en.s4);
      vld4_q <= en.s4 || (vld4_q && !out_ready_i);
    end
  end

  // Request tag travels alongside the lane data.
  aqpc_pkg::aqpc_tag_t tag_in, tag1_q, tag2_q, tag3_q;

  assign tag_in.op     = operation_i;
  assign tag_in.has_hi = has_hi_i;

  always_ff @(posedge clk_i) begin
    if (en.s1) begin
      tag1_q <= tag_in;
    end
    if (en.s2) begin
      tag2_q <= tag1_q;
    end
    if (en.s3) begin
      tag3_q <= tag2_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Unpack the code byte into per-lane codes (sign extend in signed mode).
  // ---------------------------------------------------------------------------
  logic signed [aqpc_pkg::CODE_W-1:0] lo_code_in, hi_code_in;
  logic [3:0]                         lo_nib, hi_nib;

  assign lo_nib = code_in_i[3:0];
  assign hi_nib = code_in_i[7:4];

  always_comb begin
    if (code_bits_q == aqpc_pkg::CB_8BIT) begin
      lo_code_in = signed_codes_q ? $signed({code_in_i[7], code_in_i})
                                  : $signed({1'b0, code_in_i});
      hi_code_in = '0;
    end else begin
      lo_code_in = signed_codes_q ? $signed({{5{lo_nib[3]}}, lo_nib})
                                  : $signed({5'b0, lo_nib});
      hi_code_in = signed_codes_q ? $signed({{5{hi_nib[3]}}, hi_nib})
                                  : $signed({5'b0, hi_nib});
    end
  end

  // ---------------------------------------------------------------------------
  // Two lanes: low element / low nibble and high element / high nibble.
  // ---------------------------------------------------------------------------
  logic signed [aqpc_pkg::CODE_W-1:0] lo_code, hi_code;
  logic signed [VALUE_WIDTH-1:0]      lo_real, hi_real;

  aqpc_lane #(
    .FRAC_BITS   (FRAC_BITS),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_lane_lo (
    .clk_i   (clk_i),
    .en_i    (en),
    .cfg_i   (cfg),
    .value_i (value_lo_i),
    .code_i  (lo_code_in),
    .code_o  (lo_code),
    .real_o  (lo_real)
  );

  aqpc_lane #(
    .FRAC_BITS   (FRAC_BITS),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_lane_hi (
    .clk_i   (clk_i),
    .en_i    (en),
    .cfg_i   (cfg),
    .value_i (value_hi_i),
    .code_i  (hi_code_in),
    .code_o  (hi_code),
    .real_o  (hi_real)
  );

  // Pack/select lane results into the output register.
  aqpc_merge #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_merge (
    .clk_i       (clk_i),
    .load_i      (en.s4),
    .tag_i       (tag3_q),
    .code_bits_i (code_bits_q),
    .lo_code_i   (lo_code),
    .hi_code_i   (hi_code),
    .lo_real_i   (lo_real),
    .hi_real_i   (hi_real),
    .code_out_o  (code_out_o),
    .real_lo_o   (real_lo_o),
    .real_hi_o   (real_hi_o)
  );

endmodule

@@ src/aqpc_checker.sv @@
module aqpc_checker #(
  parameter int VALUE_WIDTH = aqpc_pkg::VALUE_WIDTH_DEF
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic [7:0]                    code_out_o,
  input logic signed [VALUE_WIDTH-1:0] real_lo_o,
  input logic signed [VALUE_WIDTH-1:0] real_hi_o
);

  // hold a result until it is taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped before it was taken");

  // input only backs up when the output register is blocked
  a_ready_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without output backpressure");

  // a result carries either a code or real values, never both
  a_field_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (code_out_o != 8'h00) |-> (real_lo_o == '0) && (real_hi_o == '0))
    else $error("quantize result with nonzero real fields");

  // an accepted request passes through the stage registers into the output register when drained
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) ##1 out_ready_i [*3] |=> out_valid_o)
    else $error("request did not reach the output in time");

endmodule

bind affine_quantize_pack_codec_unit aqpc_checker #(
  .VALUE_WIDTH (VALUE_WIDTH)
) u_aqpc_checker (.*);
